// ===== hdl/mfm_pkg.sv =====
`timescale 1ns / 1ps
package mfm_pkg;

    // operand width codes
    localparam logic [6:0] WIDTH_8  = 7'd8;
    localparam logic [6:0] WIDTH_16 = 7'd16;
    localparam logic [6:0] WIDTH_32 = 7'd32;
    localparam logic [6:0] WIDTH_64 = 7'd64;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_BAD_SIZE = 1'b1;

    // result kind decided in the unpack stage
    typedef enum logic [2:0] {
        KIND_NORMAL,
        KIND_INT,
        KIND_ZERO,
        KIND_INF,
        KIND_NAN,
        KIND_BAD
    } kind_t;

    // per-beat control travelling alongside the data
    typedef struct packed {
        kind_t      kind;
        logic       dbl;
        logic       sign;
        logic [6:0] width;
    } ctrl_t;

endpackage

// ===== hdl/multi_format_multiplier.sv =====
`timescale 1ns / 1ps
// Integer (8/16/32/64-bit, truncated) and IEEE-754 binary32/binary64 multiplier with
// round-to-nearest-even, subnormals and a canonical quiet NaN. Fully pipelined: one beat
// per cycle through four register stages (unpack, partial products, product sum, round);
// m_axis valid follows the accepted s_axis beat through v1_reg to v4_reg, and a
// stall on m_axis holds every stage.
module multi_format_multiplier
    import mfm_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // operand_a[63:0], operand_b[127:64]
    input  logic [127:0] s_axis_tdata,
    // operand_width[6:0], unsigned_mode[7], float_mode[8]
    input  logic [8:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // product[63:0]
    output logic [63:0]  m_axis_tdata,
    // status[0]
    output logic         m_axis_tuser
);

    logic adv;
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    ctrl_t c_now, c1_reg, c2_reg, c3_reg;
    logic [63:0] sa_now, sb_now, sa1_reg, sb1_reg;
    logic signed [13:0] e_now, e1_reg, e2_reg, e3_reg;
    logic [127:0] prod_w, prod3_reg;
    logic [63:0] p_w, out_p_reg;
    logic st_w, out_s_reg;

    assign adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    mfm_unpack u_unpack (
        .operand_a(s_axis_tdata[63:0]), .operand_b(s_axis_tdata[127:64]),
        .operand_width(s_axis_tuser[6:0]), .float_mode(s_axis_tuser[8]),
        .ctrl(c_now), .sig_a(sa_now), .sig_b(sb_now), .exp_sum(e_now)
    );

    mfm_mul u_mul (.aclk(aclk), .en(adv), .x(sa1_reg), .y(sb1_reg), .prod(prod_w));

    mfm_round u_round (
        .ctrl(c3_reg), .prod(prod3_reg), .exp_sum(e3_reg), .product(p_w), .status(st_w)
    );

    // advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0; v4_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_axis_tvalid; v2_reg <= v1_reg; v3_reg <= v2_reg; v4_reg <= v3_reg;
        end
    end

    // advance payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            c1_reg <= c_now; sa1_reg <= sa_now; sb1_reg <= sb_now; e1_reg <= e_now;
            c2_reg <= c1_reg; e2_reg <= e1_reg;
            c3_reg <= c2_reg; e3_reg <= e2_reg; prod3_reg <= prod_w;
            out_p_reg <= p_w; out_s_reg <= st_w;
        end
    end

    assign m_axis_tvalid = v4_reg;
    assign m_axis_tdata  = out_p_reg;
    assign m_axis_tuser  = out_s_reg;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tuser))
        else $error("result changed under stall");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready) else $error("input stalled with empty output");
    a_bad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser == STATUS_BAD_SIZE) |-> m_axis_tdata == 64'd0)
        else $error("bad size with non-zero product");

endmodule

// ===== hdl/mfm_unpack.sv =====
`timescale 1ns / 1ps
// Decode operands: classify, normalise subnormal significands, form the exponent sum.
module mfm_unpack
    import mfm_pkg::*;
(
    input  logic [63:0] operand_a,
    input  logic [63:0] operand_b,
    input  logic [6:0]  operand_width,
    input  logic        float_mode,
    output ctrl_t       ctrl,
    output logic [63:0] sig_a,
    output logic [63:0] sig_b,
    output logic signed [13:0] exp_sum
);

    function automatic logic [5:0] lzc53(input logic [52:0] v);
        logic [5:0] n;
        n = 6'd53;
        for (int i = 0; i < 53; i++) begin
            if (v[i]) n = 6'(52 - i);
        end
        return n;
    endfunction

    logic        dbl;
    logic [10:0] ea, eb;
    logic [51:0] fa, fb;
    logic        sa, sb;
    logic [10:0] emax;
    logic        za, zb, ia, ib, na, nb;
    logic [52:0] ma, mb;
    logic [5:0]  la, lb;
    logic signed [13:0] xa, xb, bias;

    always_comb begin
        dbl = (operand_width == WIDTH_64);
        if (dbl) begin
            ea = operand_a[62:52]; fa = operand_a[51:0]; sa = operand_a[63];
            eb = operand_b[62:52]; fb = operand_b[51:0]; sb = operand_b[63];
            emax = 11'h7FF; bias = 14'sd1023;
        end else begin
            ea = {3'd0, operand_a[30:23]}; fa = {operand_a[22:0], 29'd0};
            sa = operand_a[31];
            eb = {3'd0, operand_b[30:23]}; fb = {operand_b[22:0], 29'd0};
            sb = operand_b[31];
            emax = 11'h0FF; bias = 14'sd127;
        end
        za = (ea == 11'd0) && (fa == 52'd0);
        zb = (eb == 11'd0) && (fb == 52'd0);
        ia = (ea == emax) && (fa == 52'd0);
        ib = (eb == emax) && (fb == 52'd0);
        na = (ea == emax) && (fa != 52'd0);
        nb = (eb == emax) && (fb != 52'd0);
        // significands aligned with the leading one at bit 52
        ma = {(ea != 11'd0), fa};
        mb = {(eb != 11'd0), fb};
        la = lzc53(ma);
        lb = lzc53(mb);
        xa = (ea == 11'd0) ? 14'sd1 - $signed({8'd0, la}) : $signed({3'd0, ea});
        xb = (eb == 11'd0) ? 14'sd1 - $signed({8'd0, lb}) : $signed({3'd0, eb});
        exp_sum = xa + xb - bias;

        ctrl.dbl   = dbl;
        ctrl.sign  = sa ^ sb;
        ctrl.width = operand_width;
        sig_a = operand_a;
        sig_b = operand_b;
        if (!float_mode) begin
            ctrl.kind = (operand_width == WIDTH_8 || operand_width == WIDTH_16 ||
                         operand_width == WIDTH_32 || operand_width == WIDTH_64)
                        ? KIND_INT : KIND_BAD;
        end else if (operand_width != WIDTH_32 && operand_width != WIDTH_64) begin
            ctrl.kind = KIND_BAD;
        end else if (na || nb || ((ia || ib) && (za || zb))) begin
            ctrl.kind = KIND_NAN;
        end else if (ia || ib) begin
            ctrl.kind = KIND_INF;
        end else if (za || zb) begin
            ctrl.kind = KIND_ZERO;
        end else begin
            ctrl.kind = KIND_NORMAL;
            sig_a = {11'd0, ma << la};
            sig_b = {11'd0, mb << lb};
        end
    end

endmodule

// ===== hdl/mfm_round.sv =====
`timescale 1ns / 1ps
// Normalise the 106-bit significand product, denormalise, round to nearest even, pack.
module mfm_round
    import mfm_pkg::*;
(
    input  ctrl_t        ctrl,
    input  logic [127:0] prod,
    input  logic signed [13:0] exp_sum,
    output logic [63:0]  product,
    output logic         status
);

    logic        top, st0, sticky, lsb, rnd;
    logic [63:0] r;
    logic signed [14:0] rexp;
    logic [14:0] d;
    logic [63:0] shifted, q, bits, inf, qnan, sgn;
    logic [5:0]  sh;
    logic [63:0] mask, rem, half;
    logic [6:0]  w;

    always_comb begin
        top = prod[105];
        rexp = 15'(exp_sum) + 15'(top);
        // leading one to bit 62, sticky below
        if (top) begin
            r = {1'b0, prod[105:43]} | 64'(prod[42:0] != 43'd0);
        end else begin
            r = {1'b0, prod[104:42]} | 64'(prod[41:0] != 42'd0);
        end
        shifted = r;
        d       = 15'd0;
        mask    = 64'd0;
        if (rexp <= 15'sd0) begin
            d = 15'(15'sd1 - rexp);
            if (d >= 15'd64) begin
                shifted = 64'(r != 64'd0);
            end else begin
                mask = (64'd1 << d[5:0]) - 64'd1;
                shifted = (r >> d[5:0]) | 64'((r & mask) != 64'd0);
            end
        end
        sh   = ctrl.dbl ? 6'd10 : 6'd39;
        q    = shifted >> sh;
        rem  = shifted & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 6'd1);
        lsb  = q[0];
        rnd  = (rem > half) || ((rem == half) && lsb);
        sticky = rnd;
        st0 = (rexp <= 15'sd0);
        bits = ((ctrl.dbl ? {49'd0, st0 ? 15'd0 : 15'(rexp - 15'sd1)} << 52
                          : {49'd0, st0 ? 15'd0 : 15'(rexp - 15'sd1)} << 23)) + q + 64'(sticky);
        inf  = ctrl.dbl ? 64'h7FF0_0000_0000_0000 : 64'h0000_0000_7F80_0000;
        qnan = ctrl.dbl ? 64'h7FF8_0000_0000_0000 : 64'h0000_0000_7FC0_0000;
        sgn  = ctrl.dbl ? {ctrl.sign, 63'd0} : {32'd0, ctrl.sign, 31'd0};
        w    = ctrl.width;
        status  = STATUS_OK;
        product = 64'd0;
        unique case (ctrl.kind)
            KIND_INT: begin
                unique case (w)
                    WIDTH_8:  product = {56'd0, prod[7:0]};
                    WIDTH_16: product = {48'd0, prod[15:0]};
                    WIDTH_32: product = {32'd0, prod[31:0]};
                    default:  product = prod[63:0];
                endcase
            end
            KIND_ZERO: product = sgn;
            KIND_INF:  product = sgn | inf;
            KIND_NAN:  product = qnan;
            KIND_NORMAL: begin
                if (rexp >= (ctrl.dbl ? 15'sd2047 : 15'sd255) || bits >= inf) begin
                    product = sgn | inf;
                end else begin
                    product = sgn | bits;
                end
            end
            default: status = STATUS_BAD_SIZE;
        endcase
    end

endmodule

// ===== hdl/mfm_mul.sv =====
`timescale 1ns / 1ps
// 64x64 multiply as four 32x32 partial products, summed in the following stage.
module mfm_mul (
    input  logic         aclk,
    input  logic         en,
    input  logic [63:0]  x,
    input  logic [63:0]  y,
    output logic [127:0] prod
);

    logic [63:0] ll_reg, lh_reg, hl_reg, hh_reg;

    // partial products
    always_ff @(posedge aclk) begin
        if (en) begin
            ll_reg <= 64'(x[31:0])  * 64'(y[31:0]);
            lh_reg <= 64'(x[31:0])  * 64'(y[63:32]);
            hl_reg <= 64'(x[63:32]) * 64'(y[31:0]);
            hh_reg <= 64'(x[63:32]) * 64'(y[63:32]);
        end
    end

    assign prod = {64'd0, ll_reg} + ({64'd0, lh_reg} << 32) + ({64'd0, hl_reg} << 32)
                + {hh_reg, 64'd0};

endmodule
